// File: hw/rtl/icso_pkg.sv
// ----------------------------------------------------------------------------
// icso_pkg
// Shared types, codes and orientation tables for the IMU calibrate, scale
// and orient unit.
// ----------------------------------------------------------------------------
package icso_pkg;

   // Field widths
   localparam int RAW_W    = 16;
   localparam int ACC_W    = 26;
   localparam int GYR_W    = 27;
   localparam int TEMP_W   = 17;
   localparam int SUM_W    = 22;
   localparam int ABIAS_W  = 23;
   localparam int GBIAS_W  = 22;
   localparam int CNT_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   // Number of calibration beats summed into one set of biases.
   localparam int CAL_SAMPLES = 64;
   localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);

   // One g in accel units (2^-20 g).
   localparam logic signed [ABIAS_W-1:0] ONE_G = ABIAS_W'(1 << 20);

   // Temperature offset of 23 C in 1/512 degree units.
   localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = TEMP_W'(11776);

   localparam logic [2:0] GYRO_RANGE_MAX = 3'd4;
   localparam logic [3:0] FRAC_SHIFT     = 4'd6;

   // Operation and result codes
   localparam logic OP_MEASURE   = 1'b0;
   localparam logic OP_CALIBRATE = 1'b1;
   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_CAL     = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MOUNT_ORIENTATION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_RANGE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_RANGE        = 2'd2;

   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [ABIAS_W-1:0] abias_type;
   typedef logic signed [GBIAS_W-1:0] gbias_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [GYR_W-1:0]   gyr_type;

   // Per orientation and output axis: source sensor axis and negate flag.
   localparam logic [1:0] REMAP_SRC [8][3] = '{
      '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd0, 2'd2}, '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd0, 2'd2},
      '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}
   };
   localparam logic REMAP_NEG [8][3] = '{
      '{1'b0, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0},
      '{1'b1, 1'b1, 1'b1}, '{1'b1, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b0}
   };
   localparam logic [1:0] GRAVITY_AXIS [8] = '{
      2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd1
   };

endpackage

// File: hw/rtl/imu_calibrate_scale_orient_unit.sv
// A measure beat, or the last calibration beat, yields a result beat that is valid in the cycle after it is accepted.
// Throughput: one request beat per cycle; the single result register is
// refilled in the cycle it is taken, so a stall on rsp only holds req off.
// Reset (synchronous, active high) restores orientation 0, 16g, 2000 dps,
// clears the running sums, the calibration count and the biases.
// ----------------------------------------------------------------------------
// imu_calibrate_scale_orient_unit
// Scales raw six-axis samples by range, removes stored biases and remaps
// the axes by mounting orientation; accumulates calibration beats into biases.
// ----------------------------------------------------------------------------
module imu_calibrate_scale_orient_unit
   import icso_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_write_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic signed [RAW_W-1:0]       req_gyro_x_raw,
   input  logic signed [RAW_W-1:0]       req_gyro_y_raw,
   input  logic signed [RAW_W-1:0]       req_gyro_z_raw,
   input  logic signed [RAW_W-1:0]       req_accel_x_raw,
   input  logic signed [RAW_W-1:0]       req_accel_y_raw,
   input  logic signed [RAW_W-1:0]       req_accel_z_raw,
   input  logic signed [RAW_W-1:0]       req_temp_raw,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic signed [ACC_W-1:0]       rsp_accel_x_out,
   output logic signed [ACC_W-1:0]       rsp_accel_y_out,
   output logic signed [ACC_W-1:0]       rsp_accel_z_out,
   output logic signed [GYR_W-1:0]       rsp_gyro_x_out,
   output logic signed [GYR_W-1:0]       rsp_gyro_y_out,
   output logic signed [GYR_W-1:0]       rsp_gyro_z_out,
   output logic signed [TEMP_W-1:0]      rsp_temperature_out
);

   // Configuration registers
   logic [2:0] orient_ff;
   logic [1:0] accel_range_ff;
   logic [2:0] gyro_range_ff;

   // Calibration state
   sum_type          accel_sum_ff [3];
   sum_type          gyro_sum_ff  [3];
   abias_type        accel_bias_ff [3];
   gbias_type        gyro_bias_ff  [3];
   logic [CNT_W-1:0] cal_count_ff;

   // Result register
   logic             rsp_valid_ff;
   logic             rsp_kind_ff;
   acc_type          rsp_accel_ff [3];
   gyr_type          rsp_gyro_ff  [3];
   logic signed [TEMP_W-1:0] rsp_temp_ff;

   logic             req_fire;
   logic             cal_beat;
   logic             cal_last;
   logic signed [RAW_W-1:0] accel_raw [3];
   logic signed [RAW_W-1:0] gyro_raw  [3];

   sum_type          accel_sum_in  [3];
   sum_type          gyro_sum_in   [3];
   abias_type        accel_bias_in [3];
   gbias_type        gyro_bias_in  [3];
   acc_type          accel_meas    [3];
   gyr_type          gyro_meas     [3];
   acc_type          accel_res_in  [3];
   gyr_type          gyro_res_in   [3];
   logic signed [TEMP_W-1:0] temp_res_in;
   logic [3:0]       accel_shift;
   logic [3:0]       gyro_shift;
   logic [2:0]       gyro_range_sat;
   logic [1:0]       grav_axis;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign cal_beat  = req_fire && (req_op == OP_CALIBRATE);
   assign cal_last  = cal_beat && (cal_count_ff == CAL_LAST);

   assign accel_raw[0] = req_accel_x_raw;
   assign accel_raw[1] = req_accel_y_raw;
   assign accel_raw[2] = req_accel_z_raw;
   assign gyro_raw[0]  = req_gyro_x_raw;
   assign gyro_raw[1]  = req_gyro_y_raw;
   assign gyro_raw[2]  = req_gyro_z_raw;

   assign gyro_range_sat = (gyro_range_ff > GYRO_RANGE_MAX) ? GYRO_RANGE_MAX : gyro_range_ff;
   assign accel_shift    = {2'b00, accel_range_ff} + FRAC_SHIFT;
   assign gyro_shift     = {1'b0, gyro_range_sat} + FRAC_SHIFT;
   assign grav_axis      = GRAVITY_AXIS[orient_ff];

   // Calibration: running sums and the biases formed on the last beat.
   always_comb begin
      abias_type sum_ext;
      for (int i = 0; i < 3; i++) begin
         accel_sum_in[i] = accel_sum_ff[i] + SUM_W'(accel_raw[i]);
         gyro_sum_in[i]  = gyro_sum_ff[i] + SUM_W'(gyro_raw[i]);
         sum_ext = ABIAS_W'(accel_sum_in[i]);
         if (grav_axis == 2'(i)) begin
            // Strictly positive sum loses one g, zero or negative gains one.
            if (sum_ext > 0) begin
               accel_bias_in[i] = sum_ext - ONE_G;
            end else begin
               accel_bias_in[i] = sum_ext + ONE_G;
            end
         end else begin
            accel_bias_in[i] = sum_ext;
         end
         gyro_bias_in[i] = gyro_sum_in[i];
      end
   end

   // Measurement: scale, remove bias, flip X and Y, then remap.
   always_comb begin
      acc_type a_scaled;
      gyr_type g_scaled;
      logic [1:0] src;
      for (int i = 0; i < 3; i++) begin
         a_scaled = ACC_W'(accel_raw[i]) <<< accel_shift;
         g_scaled = GYR_W'(gyro_raw[i]) <<< gyro_shift;
         accel_meas[i] = a_scaled - ACC_W'(accel_bias_ff[i]);
         gyro_meas[i]  = g_scaled - GYR_W'(gyro_bias_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         src = REMAP_SRC[orient_ff][i];
         // The X and Y flip folds into the remap negate flag.
         if (REMAP_NEG[orient_ff][i] ^ (src != 2'd2)) begin
            accel_res_in[i] = -accel_meas[src];
            gyro_res_in[i]  = -gyro_meas[src];
         end else begin
            accel_res_in[i] = accel_meas[src];
            gyro_res_in[i]  = gyro_meas[src];
         end
      end
      temp_res_in = TEMP_W'(req_temp_raw) + TEMP_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff      <= 3'd0;
         accel_range_ff <= 2'd3;
         gyro_range_ff  <= 3'd4;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MOUNT_ORIENTATION: orient_ff      <= csr_wdata;
            CSR_ACCEL_RANGE:       accel_range_ff <= csr_wdata[1:0];
            CSR_GYRO_RANGE:        gyro_range_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_count_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            accel_sum_ff[i]  <= '0;
            gyro_sum_ff[i]   <= '0;
            accel_bias_ff[i] <= '0;
            gyro_bias_ff[i]  <= '0;
         end
      end else if (cal_beat) begin
         cal_count_ff <= cal_count_ff + 1'b1;
         for (int i = 0; i < 3; i++) begin
            if (cal_last) begin
               accel_sum_ff[i]  <= '0;
               gyro_sum_ff[i]   <= '0;
               accel_bias_ff[i] <= accel_bias_in[i];
               gyro_bias_ff[i]  <= gyro_bias_in[i];
            end else begin
               accel_sum_ff[i] <= accel_sum_in[i];
               gyro_sum_ff[i]  <= gyro_sum_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && (req_op == OP_MEASURE || cal_last)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_MEASURE) begin
         rsp_kind_ff <= KIND_MEASURE;
         rsp_temp_ff <= temp_res_in;
         for (int i = 0; i < 3; i++) begin
            rsp_accel_ff[i] <= accel_res_in[i];
            rsp_gyro_ff[i]  <= gyro_res_in[i];
         end
      end else if (cal_last) begin
         rsp_kind_ff <= KIND_CAL;
         rsp_temp_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            rsp_accel_ff[i] <= ACC_W'(accel_bias_in[i]);
            rsp_gyro_ff[i]  <= GYR_W'(gyro_bias_in[i]);
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_accel_x_out     = rsp_accel_ff[0];
   assign rsp_accel_y_out     = rsp_accel_ff[1];
   assign rsp_accel_z_out     = rsp_accel_ff[2];
   assign rsp_gyro_x_out      = rsp_gyro_ff[0];
   assign rsp_gyro_y_out      = rsp_gyro_ff[1];
   assign rsp_gyro_z_out      = rsp_gyro_ff[2];
   assign rsp_temperature_out = rsp_temp_ff;

   // The last calibration beat yields a calibration result and restarts the count.
   a_cal_result: assert property (@(posedge clock) disable iff (reset)
      cal_last |=> (rsp_valid && rsp_kind == KIND_CAL && cal_count_ff == '0))
      else $error("last calibration beat did not produce a calibration result");

   // A measure beat never disturbs the calibration count.
   a_measure_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_MEASURE) |=> $stable(cal_count_ff))
      else $error("measure beat changed the calibration count");

   // A calibration beat before the last advances the count by one.
   a_partial_cal: assert property (@(posedge clock) disable iff (reset)
      (cal_beat && !cal_last) |=> (cal_count_ff == $past(cal_count_ff) + 1'b1))
      else $error("calibration count did not advance");

   // Calibration results carry a zero temperature.
   a_cal_temp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_CAL) |-> (rsp_temperature_out == '0))
      else $error("calibration result has nonzero temperature");

endmodule
